// ----- rtl/u8d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int unsigned MAX_RES = 4;
	localparam int unsigned PEND_DEPTH = 3;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;
	localparam logic [7:0] PAYLOAD_MASK = 8'h3F;
	localparam logic [7:0] ASCII_MAX  = 8'h7F;

	localparam logic [20:0] MIN_CP2  = 21'h000080;
	localparam logic [20:0] MIN_CP3  = 21'h000800;
	localparam logic [20:0] SURR_LO  = 21'h00D800;
	localparam logic [20:0] SURR_HI  = 21'h00DFFF;
	localparam logic [20:0] MIN_CP4  = 21'h010000;
	localparam logic [20:0] MAX_CP   = 21'h10FFFF;

	// sequence lengths held in the expected-length register
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        is_valid;
		logic [2:0]  byte_count;
	} res_t;

	typedef struct packed {
		logic       load;
		logic [1:0] head;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] n_res;
	} dp_stat_t;

endpackage : u8d_pkg
`default_nettype wire

// ----- rtl/u8d_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_in_if
// Byte channel into the decoder: valid/ready plus text byte and end mark.
// ----------------------------------------------------------------------------
interface u8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface : u8d_in_if
`default_nettype wire

// ----- rtl/u8d_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_if
// Result channel out of the decoder: valid/ready plus one decoded result.
// ----------------------------------------------------------------------------
interface u8d_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        is_valid;
	logic [2:0]  byte_count;
	logic        run_last;
	logic        text_done;

	modport source (output valid, output code_point, output is_valid, output byte_count,
		output run_last, output text_done, input ready);
	modport sink   (input valid, input code_point, input is_valid, input byte_count,
		input run_last, input text_done, output ready);
endinterface : u8d_out_if
`default_nettype wire

// ----- rtl/u8d_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_ctrl
// Controller: accepts bytes and sequences the result list out one beat at
// a time.
// ----------------------------------------------------------------------------
module u8d_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire u8d_pkg::dp_stat_t stat,
	output u8d_pkg::dp_cmd_t       cmd
);
	import u8d_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [2:0]  rem_q, rem_d;
	logic [1:0]  head_q, head_d;
	logic        in_fire, out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= 3'd0;
			head_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			head_q  <= head_d;
		end
	end

	always_comb begin
		out_valid = (state_q == ST_EMIT);
		// a new byte may come in alongside the final beat of the previous one
		in_ready  = (state_q == ST_IDLE) || (rem_q == 3'd1 && out_ready);
		in_fire   = in_valid && in_ready;
		out_fire  = out_valid && out_ready;

		state_d = state_q;
		rem_d   = rem_q;
		head_d  = head_q;

		unique case (state_q)
			ST_IDLE: begin
			end
			ST_EMIT: begin
				if (out_fire) begin
					rem_d  = rem_q - 3'd1;
					head_d = head_q + 2'd1;
					if (rem_q == 3'd1) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (in_fire && stat.n_res != 3'd0) begin
			state_d = ST_EMIT;
			rem_d   = stat.n_res;
			head_d  = 2'd0;
		end

		cmd.load = in_fire;
		cmd.head = head_q;
		cmd.last = (rem_q == 3'd1);
	end

endmodule : u8d_ctrl
`default_nettype wire

// ----- rtl/u8d_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_datapath
// Pending-byte buffer, sequence decode and validation, and the result list
// that the controller drains.
// ----------------------------------------------------------------------------
module u8d_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       text_byte,
	input  wire logic             end_of_text,
	input  wire u8d_pkg::dp_cmd_t cmd,
	output u8d_pkg::dp_stat_t     stat,
	output logic [20:0]           code_point,
	output logic                  is_valid,
	output logic [2:0]            byte_count,
	output logic                  run_last,
	output logic                  text_done
);
	import u8d_pkg::*;

	logic [7:0] pend_q [PEND_DEPTH];
	logic [7:0] pend_d [PEND_DEPTH];
	logic [1:0] pcnt_q, pcnt_d;
	logic [2:0] elen_q, elen_d;
	res_t       list_q [MAX_RES];
	res_t       list_d [MAX_RES];
	logic       eot_q;

	logic        is_cont, seq_open, finish;
	logic        ok_fin, fail_fin, append, new_lead;
	logic        lead_ascii;
	logic [2:0]  lead_len;
	logic [20:0] cp;
	logic        cp_ok;
	logic [1:0]  pfx;
	logic        has_tail;
	res_t        tail;

	always_comb begin
		is_cont  = (text_byte & CONT_MASK) == CONT_TAG;
		seq_open = (elen_q != LEN_NONE);
		finish   = ({1'b0, pcnt_q} + 3'd1 >= elen_q) || (pcnt_q == 2'd3);

		lead_ascii = (text_byte <= ASCII_MAX);
		priority if ((text_byte & LEAD2_MASK) == LEAD2_TAG) lead_len = LEN_TWO;
		else if ((text_byte & LEAD3_MASK) == LEAD3_TAG)     lead_len = LEN_THREE;
		else if ((text_byte & LEAD4_MASK) == LEAD4_TAG)     lead_len = LEN_FOUR;
		else                                                lead_len = LEN_NONE;

		unique case (elen_q)
			LEN_TWO: begin
				cp    = {10'd0, pend_q[0][4:0], text_byte[5:0]};
				cp_ok = cp >= MIN_CP2;
			end
			LEN_THREE: begin
				cp    = {5'd0, pend_q[0][3:0], pend_q[1][5:0], text_byte[5:0]};
				cp_ok = (cp >= MIN_CP3) && !(cp >= SURR_LO && cp <= SURR_HI);
			end
			default: begin
				cp    = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0],
					text_byte[5:0]};
				cp_ok = (cp >= MIN_CP4) && (cp <= MAX_CP);
			end
		endcase

		ok_fin   = seq_open && is_cont && finish && cp_ok;
		fail_fin = seq_open && is_cont && finish && !cp_ok;
		append   = seq_open && is_cont && !finish;
		new_lead = !(seq_open && is_cont);

		// buffered bytes that go out as invalid beats ahead of the tail
		pfx = (seq_open && (!is_cont || fail_fin || (append && end_of_text))) ? pcnt_q : 2'd0;

		tail.code_point = {13'd0, text_byte};
		tail.is_valid   = 1'b0;
		tail.byte_count = LEN_ONE;
		has_tail        = 1'b0;
		if (ok_fin) begin
			tail.code_point = cp;
			tail.is_valid   = 1'b1;
			tail.byte_count = elen_q;
			has_tail        = 1'b1;
		end else if (fail_fin) begin
			has_tail = 1'b1;
		end else if (append) begin
			has_tail = end_of_text;
		end else if (lead_ascii) begin
			tail.is_valid = 1'b1;
			has_tail      = 1'b1;
		end else if (lead_len == LEN_NONE) begin
			has_tail = 1'b1;
		end else begin
			// a lone lead at end of text is flushed straight away
			has_tail = end_of_text;
		end

		for (int i = 0; i < PEND_DEPTH; i++) begin
			if (i < pfx) begin
				list_d[i].code_point = {13'd0, pend_q[2'(i)]};
				list_d[i].is_valid   = 1'b0;
				list_d[i].byte_count = LEN_ONE;
			end else begin
				list_d[i] = tail;
			end
		end
		list_d[MAX_RES-1] = tail;

		stat.n_res = {1'b0, pfx} + {2'd0, has_tail};

		pend_d = pend_q;
		pcnt_d = 2'd0;
		elen_d = LEN_NONE;
		if (append && !end_of_text) begin
			pend_d[pcnt_q] = text_byte;
			pcnt_d         = pcnt_q + 2'd1;
			elen_d         = elen_q;
		end else if (new_lead && !lead_ascii && lead_len != LEN_NONE && !end_of_text) begin
			pend_d[0] = text_byte;
			pcnt_d    = 2'd1;
			elen_d    = lead_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PEND_DEPTH; i++) begin
				pend_q[i] <= 8'd0;
			end
			pcnt_q <= 2'd0;
			elen_q <= LEN_NONE;
		end else if (cmd.load) begin
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
			elen_q <= elen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			list_q <= list_d;
			eot_q  <= end_of_text;
		end
	end

	always_comb begin
		code_point = list_q[cmd.head].code_point;
		is_valid   = list_q[cmd.head].is_valid;
		byte_count = list_q[cmd.head].byte_count;
		run_last   = cmd.last;
		text_done  = cmd.last && eot_q;
	end

endmodule : u8d_datapath
`default_nettype wire

// ----- rtl/utf8_stream_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 decoder with validation over a byte stream.
// ----------------------------------------------------------------------------
// One byte enters per accepted beat on the text channel. The results of a
// byte are held in a four-entry list and leave through the result channel
// one per cycle while the result channel is ready, and the next byte is
// taken in the same cycle as the last result of the previous one is taken.
// Well-formed text therefore runs at one byte per cycle while results are
// taken as offered; a rejected sequence holds off the next byte while its
// buffered bytes leave as separate results. Bytes that only open or extend
// a sequence produce no result. Results carry run_last on the final beat of
// each byte and text_done on the final beat of a byte marked end_of_text.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
	input  wire logic clk,
	input  wire logic arst_n,
	u8d_in_if.sink    text,
	u8d_out_if.source result
);
	import u8d_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	u8d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_ready  (text.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	u8d_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text.text_byte),
		.end_of_text (text.end_of_text),
		.cmd         (cmd),
		.stat        (stat),
		.code_point  (result.code_point),
		.is_valid    (result.is_valid),
		.byte_count  (result.byte_count),
		.run_last    (result.run_last),
		.text_done   (result.text_done)
	);

	// a byte is only taken once every earlier result has gone or is going
	a_accept_after_drain : assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready |-> !result.valid || (result.ready && result.run_last))
	else $error("byte accepted while results still queued");

	a_done_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.text_done |-> result.run_last)
	else $error("text_done without run_last");

	a_invalid_single : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.is_valid |-> result.byte_count == LEN_ONE)
	else $error("rejected beat with byte_count other than one");

	a_end_gives_result : assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready && text.end_of_text |=> result.valid)
	else $error("end of text produced no result");

endmodule : utf8_stream_decoder_top
`default_nettype wire
